// ===== rtl/c8i_pkg.sv =====
`default_nettype none

package c8i_pkg;

    // host operation codes
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_STEP   = 3'd1;
    localparam logic [2:0] OP_PIXEL  = 3'd2;
    localparam logic [2:0] OP_MEMRD  = 3'd3;
    localparam logic [2:0] OP_REGRD  = 3'd4;

    // field widths
    localparam int OP_W   = 3;
    localparam int ADDR_W = 12;
    localparam int DATA_W = 8;
    localparam int PX_W   = 6;
    localparam int PY_W   = 5;
    localparam int WORD_W = 16;

    // display and register file geometry
    localparam int SCREEN_W  = 64;
    localparam int SCREEN_H  = 32;
    localparam int REG_COUNT = 16;
    localparam int REG_W     = 4;

    // instruction groups (top nibble)
    localparam logic [3:0] INS_SYS  = 4'h0;
    localparam logic [3:0] INS_JUMP = 4'h1;
    localparam logic [3:0] INS_SETV = 4'h6;
    localparam logic [3:0] INS_ADDV = 4'h7;
    localparam logic [3:0] INS_SETI = 4'hA;
    localparam logic [3:0] INS_DRAW = 4'hD;

    localparam logic [11:0] CLS_NNN  = 12'h0E0;
    localparam logic [3:0]  VF_INDEX = 4'hF;
    localparam logic [11:0] PC_RESET = 12'h200;

endpackage

`default_nettype wire

// ===== rtl/c8i_ram.sv =====
`default_nettype none

module c8i_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/chip8_subset_interpreter.sv =====
`default_nettype none

// Small CHIP-8 core: the host writes program bytes, steps one instruction per item
// (00E0, 1NNN, 6XNN, 7XNN, ANNN, DXYN; other words only advance the counter) and reads
// back pixels, memory bytes or V registers, one result item per input item. Main memory,
// frame rows and V registers live in single-read-port RAMs with a registered read. DXYN
// draws at most 15 sprite rows. After reset the block sweeps all MEM_BYTES bytes of main
// memory to zero, one byte a cycle, with in_stall high. A new item is taken while the
// previous result still waits on out_stall.
module chip8_subset_interpreter #(
    parameter int MEM_BYTES = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [c8i_pkg::OP_W-1:0]     opcode,
    input  wire logic [c8i_pkg::ADDR_W-1:0]   address,
    input  wire logic [c8i_pkg::DATA_W-1:0]   data,
    input  wire logic [c8i_pkg::PX_W-1:0]     pixel_x,
    input  wire logic [c8i_pkg::PY_W-1:0]     pixel_y,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [c8i_pkg::DATA_W-1:0]        read_data,
    output logic [c8i_pkg::ADDR_W-1:0]        pc_value,
    output logic [c8i_pkg::WORD_W-1:0]        executed_word
);

    localparam int AW = $clog2(MEM_BYTES);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_FETCH1 = 4'd3;
    localparam logic [3:0] S_FETCH2 = 4'd4;
    localparam logic [3:0] S_EXEC   = 4'd5;
    localparam logic [3:0] S_ADD    = 4'd6;
    localparam logic [3:0] S_DRAW_X = 4'd7;
    localparam logic [3:0] S_DRAW_Y = 4'd8;
    localparam logic [3:0] S_ROW_RD = 4'd9;
    localparam logic [3:0] S_ROW_WR = 4'd10;
    localparam logic [3:0] S_PIXEL  = 4'd11;
    localparam logic [3:0] S_MEMRD  = 4'd12;
    localparam logic [3:0] S_REGRD  = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    // address reduction modulo the memory size; inputs stay below 5 * MEM_BYTES
    function automatic logic [AW-1:0] mem_mod(input logic [12:0] a);
        logic [12:0] v;
        v = a;
        for (int i = 0; i < 4; i++)
        begin
            if (v >= 13'(MEM_BYTES))
            begin
                v = v - 13'(MEM_BYTES);
            end
        end
        return v[AW-1:0];
    endfunction

    // control
    logic [3:0]                            state_reg, state_next;
    logic [AW-1:0]                         clr_reg, clr_next;
    logic [c8i_pkg::SCREEN_H-1:0]          fvalid_reg, fvalid_next;
    logic [c8i_pkg::REG_COUNT-1:0]         rvalid_reg, rvalid_next;
    logic [11:0]                           pc_reg, pc_next;
    logic [11:0]                           ip_reg, ip_next;
    logic                                  out_valid_reg, out_valid_next;

    // payload
    logic [c8i_pkg::OP_W-1:0]              op_reg, op_next;
    logic [c8i_pkg::ADDR_W-1:0]            addr_reg, addr_next;
    logic [c8i_pkg::DATA_W-1:0]            data_reg, data_next;
    logic [c8i_pkg::PX_W-1:0]              px_reg, px_next;
    logic [c8i_pkg::PY_W-1:0]              py_reg, py_next;
    logic [c8i_pkg::WORD_W-1:0]            word_reg, word_next;
    logic [7:0]                            rd_reg, rd_next;
    logic [5:0]                            x0_reg, x0_next;
    logic [4:0]                            y0_reg, y0_next;
    logic [3:0]                            row_reg, row_next;
    logic                                  coll_reg, coll_next;
    logic [7:0]                            out_rd_reg, out_rd_next;
    logic [11:0]                           out_pc_reg, out_pc_next;
    logic [c8i_pkg::WORD_W-1:0]            out_word_reg, out_word_next;

    // RAM ports
    logic                                  mem_we;
    logic [AW-1:0]                         mem_waddr, mem_raddr;
    logic [7:0]                            mem_wdata, mem_rdata;
    logic                                  frame_we;
    logic [c8i_pkg::PY_W-1:0]              frame_waddr, frame_raddr;
    logic [c8i_pkg::SCREEN_W-1:0]          frame_wdata, frame_rdata;
    logic                                  reg_we;
    logic [c8i_pkg::REG_W-1:0]             reg_waddr, reg_raddr;
    logic [7:0]                            reg_wdata, reg_rdata;

    // datapath helpers
    logic [AW-1:0]                         pc_mod, pc_inc, host_addr, sprite_addr;
    logic [12:0]                           pc_plus2;
    logic [5:0]                            ysum;
    logic [7:0]                            rev;
    logic [c8i_pkg::SCREEN_W-1:0]          mask, row_cur;
    logic [3:0]                            ins_top, ins_x, ins_y, ins_n;
    logic                                  out_free;

    assign ins_top = word_reg[15:12];
    assign ins_x   = word_reg[11:8];
    assign ins_y   = word_reg[7:4];
    assign ins_n   = word_reg[3:0];

    assign pc_mod      = mem_mod({1'b0, pc_reg});
    // the second fetch byte wraps to address zero past the last byte
    assign pc_inc      = (pc_mod == AW'(MEM_BYTES - 1)) ? '0 : pc_mod + 1'b1;
    assign pc_plus2    = {{(13-AW){1'b0}}, pc_mod} + 13'd2;
    assign host_addr   = mem_mod({1'b0, addr_reg});
    assign ysum        = {1'b0, y0_reg} + {2'b00, row_reg};
    assign sprite_addr = mem_mod({1'b0, ip_reg} + {9'd0, row_reg});
    assign row_cur     = fvalid_reg[ysum[4:0]] ? frame_rdata : '0;
    assign mask        = {56'd0, rev} << x0_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    // sprite bytes draw most significant bit at the leftmost column
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            rev[b] = mem_rdata[7-b];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        fvalid_next    = fvalid_reg;
        rvalid_next    = rvalid_reg;
        pc_next        = pc_reg;
        ip_next        = ip_reg;
        out_valid_next = out_valid_reg && out_stall;
        op_next        = op_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        word_next      = word_reg;
        rd_next        = rd_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        row_next       = row_reg;
        coll_next      = coll_reg;
        out_rd_next    = out_rd_reg;
        out_pc_next    = out_pc_reg;
        out_word_next  = out_word_reg;

        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;
        frame_we    = 1'b0;
        frame_waddr = '0;
        frame_wdata = '0;
        frame_raddr = '0;
        reg_we      = 1'b0;
        reg_waddr   = '0;
        reg_wdata   = '0;
        reg_raddr   = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(MEM_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    addr_next  = address;
                    data_next  = data;
                    px_next    = pixel_x;
                    py_next    = pixel_y;
                    word_next  = '0;
                    rd_next    = '0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (op_reg)
                    c8i_pkg::OP_WRITE:
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = host_addr;
                        mem_wdata  = data_reg;
                        state_next = S_DONE;
                    end
                    c8i_pkg::OP_STEP:
                    begin
                        mem_raddr  = pc_mod;
                        state_next = S_FETCH1;
                    end
                    c8i_pkg::OP_PIXEL:
                    begin
                        frame_raddr = py_reg;
                        state_next  = S_PIXEL;
                    end
                    c8i_pkg::OP_MEMRD:
                    begin
                        mem_raddr  = host_addr;
                        state_next = S_MEMRD;
                    end
                    c8i_pkg::OP_REGRD:
                    begin
                        reg_raddr  = addr_reg[3:0];
                        state_next = S_REGRD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FETCH1:
            begin
                word_next[15:8] = mem_rdata;
                mem_raddr       = pc_inc;
                state_next      = S_FETCH2;
            end
            S_FETCH2:
            begin
                word_next[7:0] = mem_rdata;
                pc_next        = pc_plus2[11:0];
                state_next     = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (ins_top)
                    c8i_pkg::INS_SYS:
                    begin
                        if (word_reg[11:0] == c8i_pkg::CLS_NNN)
                        begin
                            fvalid_next = '0;
                        end
                    end
                    c8i_pkg::INS_JUMP:
                    begin
                        pc_next = word_reg[11:0];
                    end
                    c8i_pkg::INS_SETV:
                    begin
                        reg_we              = 1'b1;
                        reg_waddr           = ins_x;
                        reg_wdata           = word_reg[7:0];
                        rvalid_next[ins_x]  = 1'b1;
                    end
                    c8i_pkg::INS_ADDV:
                    begin
                        reg_raddr  = ins_x;
                        state_next = S_ADD;
                    end
                    c8i_pkg::INS_SETI:
                    begin
                        ip_next = word_reg[11:0];
                    end
                    c8i_pkg::INS_DRAW:
                    begin
                        reg_raddr  = ins_x;
                        state_next = S_DRAW_X;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_ADD:
            begin
                reg_we             = 1'b1;
                reg_waddr          = ins_x;
                reg_wdata          = (rvalid_reg[ins_x] ? reg_rdata : 8'd0) + word_reg[7:0];
                rvalid_next[ins_x] = 1'b1;
                state_next         = S_DONE;
            end
            S_DRAW_X:
            begin
                x0_next    = rvalid_reg[ins_x] ? reg_rdata[5:0] : 6'd0;
                reg_raddr  = ins_y;
                state_next = S_DRAW_Y;
            end
            S_DRAW_Y:
            begin
                y0_next    = rvalid_reg[ins_y] ? reg_rdata[4:0] : 5'd0;
                row_next   = '0;
                coll_next  = 1'b0;
                state_next = S_ROW_RD;
            end
            S_ROW_RD:
            begin
                if (row_reg == ins_n || ysum[5])
                begin
                    // VF is written last so that X or Y equal to F read the old value
                    reg_we                     = 1'b1;
                    reg_waddr                  = c8i_pkg::VF_INDEX;
                    reg_wdata                  = {7'd0, coll_reg};
                    rvalid_next[c8i_pkg::VF_INDEX] = 1'b1;
                    state_next                 = S_DONE;
                end
                else
                begin
                    mem_raddr   = sprite_addr;
                    frame_raddr = ysum[4:0];
                    state_next  = S_ROW_WR;
                end
            end
            S_ROW_WR:
            begin
                frame_we                = 1'b1;
                frame_waddr             = ysum[4:0];
                frame_wdata             = row_cur ^ mask;
                fvalid_next[ysum[4:0]]  = 1'b1;
                coll_next               = coll_reg | (|(row_cur & mask));
                row_next                = row_reg + 4'd1;
                state_next              = S_ROW_RD;
            end
            S_PIXEL:
            begin
                rd_next    = {7'd0, fvalid_reg[py_reg] & frame_rdata[px_reg]};
                state_next = S_DONE;
            end
            S_MEMRD:
            begin
                rd_next    = mem_rdata;
                state_next = S_DONE;
            end
            S_REGRD:
            begin
                rd_next    = rvalid_reg[addr_reg[3:0]] ? reg_rdata : 8'd0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = rd_reg;
                    out_pc_next    = pc_reg;
                    out_word_next  = word_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            fvalid_reg    <= '0;
            rvalid_reg    <= '0;
            pc_reg        <= c8i_pkg::PC_RESET;
            ip_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            fvalid_reg    <= fvalid_next;
            rvalid_reg    <= rvalid_next;
            pc_reg        <= pc_next;
            ip_reg        <= ip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        data_reg     <= data_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        word_reg     <= word_next;
        rd_reg       <= rd_next;
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        row_reg      <= row_next;
        coll_reg     <= coll_next;
        out_rd_reg   <= out_rd_next;
        out_pc_reg   <= out_pc_next;
        out_word_reg <= out_word_next;
    end

    c8i_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_main_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    c8i_ram #(
        .WIDTH (c8i_pkg::SCREEN_W),
        .DEPTH (c8i_pkg::SCREEN_H)
    ) u_frame_mem (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    c8i_ram #(
        .WIDTH (8),
        .DEPTH (c8i_pkg::REG_COUNT)
    ) u_reg_mem (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .raddr (reg_raddr),
        .rdata (reg_rdata)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign read_data     = out_rd_reg;
    assign pc_value      = out_pc_reg;
    assign executed_word = out_word_reg;

endmodule

`default_nettype wire

// ===== rtl/c8i_checker.sv =====
`default_nettype none

module c8i_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [c8i_pkg::DATA_W-1:0] read_data,
    input wire logic [c8i_pkg::ADDR_W-1:0] pc_value,
    input wire logic [c8i_pkg::WORD_W-1:0] executed_word
);

    logic [1:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // count items taken whose result has not left yet
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> in_stall)
        else $error("input taken during memory clearing");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 2'd0))
        else $error("result without an item");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two items in flight");

    a_jump_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && executed_word[15:12] == c8i_pkg::INS_JUMP)
            |-> (pc_value == executed_word[11:0]))
        else $error("jump did not load the counter");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(read_data)
            && $stable(pc_value) && $stable(executed_word)))
        else $error("stalled result changed");

endmodule

bind chip8_subset_interpreter c8i_checker u_checker (.*);

`default_nettype wire
